[design/pcbe_pkg.sv]
`default_nettype none

package pcbe_pkg;

    // field widths
    localparam int PCBE_CH_W     = 8;
    localparam int PCBE_ADDR_W   = 17;
    localparam int PCBE_CNT8_W   = 8;
    localparam int PCBE_KIND_W   = 2;
    localparam int PCBE_CFG_IDX_W = 2;
    localparam int PCBE_CFG_DAT_W = 17;

    // configuration register indexes
    localparam logic [PCBE_CFG_IDX_W-1:0] CFG_DER_CAPACITY = 2'd0;
    localparam logic [PCBE_CFG_IDX_W-1:0] CFG_MAX_CERTS    = 2'd1;

    // configuration reset values
    localparam logic [PCBE_ADDR_W-1:0] DER_CAPACITY_RST = 17'd65536;
    localparam logic [PCBE_CNT8_W-1:0] MAX_CERTS_RST    = 8'd255;

    // result kinds
    localparam logic [PCBE_KIND_W-1:0] KIND_DATA    = 2'd0;
    localparam logic [PCBE_KIND_W-1:0] KIND_SECTION = 2'd1;
    localparam logic [PCBE_KIND_W-1:0] KIND_ERROR   = 2'd2;
    localparam logic [PCBE_KIND_W-1:0] KIND_DONE    = 2'd3;

    // parser modes
    localparam logic [2:0] MODE_LINE     = 3'd0;
    localparam logic [2:0] MODE_SKIPLINE = 3'd1;
    localparam logic [2:0] MODE_SKIPHDR  = 3'd2;
    localparam logic [2:0] MODE_DATA     = 3'd3;
    localparam logic [2:0] MODE_HALT     = 3'd4;

    // results per character and result queue sizing
    localparam int PCBE_MAX_RES   = 5;
    localparam int PCBE_RES_N_W   = 3;
    localparam int PCBE_Q_DEPTH   = 8;
    localparam int PCBE_Q_PTR_W   = 3;
    localparam int PCBE_Q_CNT_W   = 4;
    localparam int PCBE_Q_SPACE   = PCBE_Q_DEPTH - PCBE_MAX_RES;

    typedef struct packed {
        logic [2:0]             mode;
        logic [4:0]             match_index;
        logic [2:0]             dash_run;
        logic [1:0]             held_count;
        logic [11:0]            bit_buffer;
        logic [3:0]             bit_count;
        logic [PCBE_ADDR_W-1:0] write_pos;
        logic [PCBE_ADDR_W-1:0] section_start;
        logic [PCBE_CNT8_W-1:0] sections_seen;
    } t_dec_state;

    typedef struct packed {
        logic [PCBE_KIND_W-1:0] kind;
        logic [PCBE_CH_W-1:0]   data_byte;
        logic [PCBE_ADDR_W-1:0] offset;
        logic [PCBE_ADDR_W-1:0] length;
        logic [PCBE_CNT8_W-1:0] cert_count;
        logic                   final_res;
    } t_result;

    typedef t_result [PCBE_MAX_RES-1:0] t_res_list;

endpackage

`default_nettype wire

[design/pcbe_in_if.sv]
`default_nettype none

interface pcbe_in_if;
    import pcbe_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [PCBE_CH_W-1:0] ch;
    logic                 last_char;

    modport source (output valid, output ch, output last_char, input ready);
    modport sink   (input valid, input ch, input last_char, output ready);
endinterface

`default_nettype wire

[design/pcbe_out_if.sv]
`default_nettype none

interface pcbe_out_if;
    import pcbe_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [PCBE_KIND_W-1:0] kind;
    logic [PCBE_CH_W-1:0]   data_byte;
    logic [PCBE_ADDR_W-1:0] offset;
    logic [PCBE_ADDR_W-1:0] length;
    logic [PCBE_CNT8_W-1:0] cert_count;
    logic                   final_res;

    modport source (output valid, output kind, output data_byte, output offset,
                    output length, output cert_count, output final_res, input ready);
    modport sink   (input valid, input kind, input data_byte, input offset,
                    input length, input cert_count, input final_res, output ready);
endinterface

`default_nettype wire

[design/pcbe_cfg_if.sv]
`default_nettype none

interface pcbe_cfg_if;
    import pcbe_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [PCBE_CFG_IDX_W-1:0] index;
    logic [PCBE_CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/pcbe_step.sv]
`default_nettype none

module pcbe_step (
    input  pcbe_pkg::t_dec_state                   i_state,
    input  logic [pcbe_pkg::PCBE_CH_W-1:0]         i_ch,
    input  logic                                   i_last,
    input  logic [pcbe_pkg::PCBE_ADDR_W-1:0]       i_der_capacity,
    input  logic [pcbe_pkg::PCBE_CNT8_W-1:0]       i_max_certs,
    output pcbe_pkg::t_dec_state                   o_state,
    output pcbe_pkg::t_res_list                    o_res,
    output logic [pcbe_pkg::PCBE_RES_N_W-1:0]      o_res_n
);
    import pcbe_pkg::*;

    localparam int MARK_LEN = 27;
    localparam logic [8*MARK_LEN-1:0] BEGIN_MARK = "-----BEGIN CERTIFICATE-----";

    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [7:0] CH_N    = 8'h4E;
    localparam logic [7:0] CH_D    = 8'h44;

    typedef struct packed {
        t_dec_state st;
        logic       emit;
        t_result    res;
    } t_feed_out;

    // character of the begin marker at a position
    function automatic logic [7:0] mark_char(input logic [4:0] idx);
        logic [7:0] c;
        c = 8'h00;
        for (int k = 0; k < MARK_LEN; k++) begin
            if (idx == 5'(k)) c = BEGIN_MARK[8*(MARK_LEN-1-k) +: 8];
        end
        return c;
    endfunction

    // base64 digit value, top bit marks a valid digit
    function automatic logic [6:0] b64_value(input logic [7:0] c);
        logic [6:0] v;
        if (c inside {[8'h41:8'h5A]})      v = {1'b1, 6'(c - 8'h41)};
        else if (c inside {[8'h61:8'h7A]}) v = {1'b1, 6'(c - 8'h61 + 8'd26)};
        else if (c inside {[8'h30:8'h39]}) v = {1'b1, 6'(c - 8'h30 + 8'd52)};
        else if (c == 8'h2B)               v = {1'b1, 6'd62};
        else if (c == 8'h2F)               v = {1'b1, 6'd63};
        else                               v = 7'd0;
        return v;
    endfunction

    // one decoder character: may give a byte or the overflow error
    function automatic t_feed_out feed(input t_dec_state s, input logic [7:0] c,
                                       input logic [PCBE_ADDR_W-1:0] cap);
        t_feed_out  f;
        logic [6:0] v;
        logic [11:0] mask;
        v = b64_value(c);
        f.st   = s;
        f.emit = 1'b0;
        f.res  = '0;
        mask   = '0;
        if (v[6]) begin
            f.st.bit_buffer = {s.bit_buffer[5:0], v[5:0]};
            f.st.bit_count  = s.bit_count + 4'd6;
            if (f.st.bit_count >= 4'd8) begin
                f.st.bit_count = f.st.bit_count - 4'd8;
                f.emit = 1'b1;
                f.res.offset     = s.write_pos;
                f.res.cert_count = s.sections_seen;
                if (s.write_pos >= cap) begin
                    f.res.kind = KIND_ERROR;
                    f.st.mode  = MODE_HALT;
                end else begin
                    f.res.kind      = KIND_DATA;
                    f.res.data_byte = 8'(f.st.bit_buffer >> f.st.bit_count);
                    f.st.write_pos  = s.write_pos + 17'd1;
                    mask            = (12'd1 << f.st.bit_count) - 12'd1;
                    f.st.bit_buffer = f.st.bit_buffer & mask;
                end
            end
        end
        return f;
    endfunction

    function automatic t_res_list put_res(input t_res_list l, input logic [2:0] idx,
                                          input t_result r);
        t_res_list o;
        o = l;
        o[idx] = r;
        return o;
    endfunction

    always_comb begin
        t_dec_state s;
        t_res_list  res;
        logic [2:0] n;
        t_feed_out  f;
        t_result    sec;
        logic       go;
        logic       ok;
        logic       do_close;

        s   = i_state;
        res = '0;
        n   = 3'd0;
        f   = '0;
        sec = '0;
        go  = 1'b1;
        ok  = 1'b1;
        do_close = 1'b0;

        // main character handling per mode
        case (s.mode)
            MODE_LINE: begin
                if (s.match_index < 5'(MARK_LEN) && i_ch == mark_char(s.match_index)) begin
                    s.match_index = s.match_index + 5'd1;
                    if (s.match_index == 5'(MARK_LEN)) begin
                        s.match_index = 5'd0;
                        s.mode        = MODE_SKIPHDR;
                    end
                end else begin
                    s.match_index = 5'd0;
                    s.mode        = (i_ch == CH_NL) ? MODE_LINE : MODE_SKIPLINE;
                end
            end
            MODE_SKIPLINE: begin
                if (i_ch == CH_NL) s.mode = MODE_LINE;
            end
            MODE_SKIPHDR: begin
                if (i_ch == CH_NL) begin
                    s.mode          = MODE_DATA;
                    s.section_start = s.write_pos;
                    s.bit_buffer    = 12'd0;
                    s.bit_count     = 4'd0;
                    s.dash_run      = 3'd0;
                    s.held_count    = 2'd0;
                end
            end
            MODE_DATA: begin
                // held marker letters
                if (s.held_count == 2'd1) begin
                    if (i_ch == CH_N) begin
                        s.held_count = 2'd2;
                        go = 1'b0;
                    end else begin
                        s.held_count = 2'd0;
                        f = feed(s, CH_E, i_der_capacity);
                        s = f.st;
                        if (f.emit) begin
                            res = put_res(res, n, f.res);
                            n   = n + 3'd1;
                        end
                        if (s.mode == MODE_HALT) go = 1'b0;
                    end
                end else if (s.held_count == 2'd2) begin
                    if (i_ch == CH_D) begin
                        s.held_count = 2'd0;
                        s.dash_run   = 3'd0;
                        do_close     = 1'b1;
                        go           = 1'b0;
                    end else begin
                        s.held_count = 2'd0;
                        f = feed(s, CH_E, i_der_capacity);
                        s = f.st;
                        if (f.emit) begin
                            res = put_res(res, n, f.res);
                            n   = n + 3'd1;
                        end
                        if (s.mode == MODE_HALT) begin
                            go = 1'b0;
                        end else begin
                            f = feed(s, CH_N, i_der_capacity);
                            s = f.st;
                            if (f.emit) begin
                                res = put_res(res, n, f.res);
                                n   = n + 3'd1;
                            end
                            if (s.mode == MODE_HALT) go = 1'b0;
                        end
                    end
                end
                // dash run, marker start or ordinary digit
                if (go) begin
                    if (i_ch == CH_DASH) begin
                        if (s.dash_run < 3'd5) s.dash_run = s.dash_run + 3'd1;
                    end else if (i_ch == CH_E && s.dash_run >= 3'd5) begin
                        s.dash_run   = 3'd0;
                        s.held_count = 2'd1;
                    end else begin
                        s.dash_run = 3'd0;
                        f = feed(s, i_ch, i_der_capacity);
                        s = f.st;
                        if (f.emit) begin
                            res = put_res(res, n, f.res);
                            n   = n + 3'd1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // end marker closes the section
        if (do_close) begin
            if (s.write_pos > s.section_start && s.sections_seen < i_max_certs) begin
                s.sections_seen = s.sections_seen + 8'd1;
                sec.kind        = KIND_SECTION;
                sec.offset      = s.section_start;
                sec.length      = s.write_pos - s.section_start;
                sec.cert_count  = s.sections_seen;
                res = put_res(res, n, sec);
                n   = n + 3'd1;
            end
            s.mode = MODE_SKIPLINE;
        end

        // end of text: flush held letters, close, report done unless halted, rearm
        if (i_last) begin
            if (s.mode == MODE_DATA) begin
                if (s.held_count >= 2'd1) begin
                    f = feed(s, CH_E, i_der_capacity);
                    s = f.st;
                    if (f.emit) begin
                        res = put_res(res, n, f.res);
                        n   = n + 3'd1;
                    end
                    ok = (s.mode != MODE_HALT);
                end
                if (ok && s.held_count == 2'd2) begin
                    f = feed(s, CH_N, i_der_capacity);
                    s = f.st;
                    if (f.emit) begin
                        res = put_res(res, n, f.res);
                        n   = n + 3'd1;
                    end
                    ok = (s.mode != MODE_HALT);
                end
                s.held_count = 2'd0;
                if (ok && s.write_pos > s.section_start &&
                    s.sections_seen < i_max_certs) begin
                    s.sections_seen = s.sections_seen + 8'd1;
                    sec.kind        = KIND_SECTION;
                    sec.offset      = s.section_start;
                    sec.length      = s.write_pos - s.section_start;
                    sec.cert_count  = s.sections_seen;
                    res = put_res(res, n, sec);
                    n   = n + 3'd1;
                end
            end
            if (s.mode != MODE_HALT) begin
                sec            = '0;
                sec.kind       = KIND_DONE;
                sec.offset     = s.write_pos;
                sec.cert_count = s.sections_seen;
                res = put_res(res, n, sec);
                n   = n + 3'd1;
            end
            s      = '0;
            s.mode = MODE_LINE;
        end

        // flag the last result of this character
        if (n != 3'd0) res[n - 3'd1].final_res = 1'b1;

        o_state = s;
        o_res   = res;
        o_res_n = n;
    end

endmodule

`default_nettype wire

[design/pcbe_result_fifo.sv]
`default_nettype none

module pcbe_result_fifo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [pcbe_pkg::PCBE_RES_N_W-1:0]   i_push_n,
    input  pcbe_pkg::t_res_list                 i_push_res,
    input  logic                                i_pop,
    output pcbe_pkg::t_result                   o_head,
    output logic                                o_valid,
    output logic                                o_space
);
    import pcbe_pkg::*;

    t_result                 r_mem [PCBE_Q_DEPTH];
    logic [PCBE_Q_PTR_W-1:0] r_wr_ptr;
    logic [PCBE_Q_PTR_W-1:0] r_rd_ptr;
    logic [PCBE_Q_CNT_W-1:0] r_count;
    logic [PCBE_Q_PTR_W-1:0] n_wr_ptr;
    logic [PCBE_Q_PTR_W-1:0] n_rd_ptr;
    logic [PCBE_Q_CNT_W-1:0] n_count;

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr + PCBE_Q_PTR_W'(i_push_n);
        n_rd_ptr = r_rd_ptr + PCBE_Q_PTR_W'(i_pop);
        n_count  = r_count + PCBE_Q_CNT_W'(i_push_n) - PCBE_Q_CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // burst write of up to a full character's results
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PCBE_MAX_RES; k++) begin
            if (PCBE_RES_N_W'(k) < i_push_n) begin
                r_mem[r_wr_ptr + PCBE_Q_PTR_W'(k)] <= i_push_res[k];
            end
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_space = (r_count <= PCBE_Q_CNT_W'(PCBE_Q_SPACE));

endmodule

`default_nettype wire

[design/pem_certificate_base64_extractor_unit.sv]
// path: accepted character -> input register -> decode into the result queue -> queue head at output
// throughput: 1 character per cycle while the result queue holds 3 or fewer entries;
// a character giving several results (up to 5) drains them one per cycle while the receiver is ready
// reset: synchronous active low; parser state clears, der_capacity to 65536,
// max_certs to 255, result queue empties
`default_nettype none

module pem_certificate_base64_extractor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcbe_in_if.sink     i_in,
    pcbe_out_if.source  o_out,
    pcbe_cfg_if.sink    i_cfg
);
    import pcbe_pkg::*;

    logic                   r_in_valid;
    logic [PCBE_CH_W-1:0]   r_ch;
    logic                   r_last;
    t_dec_state             r_state;
    logic [PCBE_ADDR_W-1:0] r_der_capacity;
    logic [PCBE_CNT8_W-1:0] r_max_certs;

    t_dec_state                step_state;
    t_res_list                 step_res;
    logic [PCBE_RES_N_W-1:0]   step_res_n;
    logic [PCBE_RES_N_W-1:0]   push_n;
    t_result                   head;
    logic                      q_valid;
    logic                      q_space;
    logic                      proc_fire;
    logic                      in_fire;

    assign proc_fire = r_in_valid && q_space;
    assign i_in.ready = !r_in_valid || proc_fire;
    assign in_fire   = i_in.valid && i_in.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ch   <= i_in.ch;
            r_last <= i_in.last_char;
        end
    end

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_der_capacity <= DER_CAPACITY_RST;
            r_max_certs    <= MAX_CERTS_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DER_CAPACITY: r_der_capacity <= i_cfg.data;
                CFG_MAX_CERTS:    r_max_certs    <= i_cfg.data[PCBE_CNT8_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // parser and decoder for one character
    pcbe_step u_step (
        .i_state        (r_state),
        .i_ch           (r_ch),
        .i_last         (r_last),
        .i_der_capacity (r_der_capacity),
        .i_max_certs    (r_max_certs),
        .o_state        (step_state),
        .o_res          (step_res),
        .o_res_n        (step_res_n)
    );

    // parser state register, mode sits in the top bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= {MODE_LINE, {($bits(t_dec_state) - 3){1'b0}}};
        end else if (proc_fire) begin
            r_state <= step_state;
        end
    end

    // result queue
    assign push_n = proc_fire ? step_res_n : '0;

    pcbe_result_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_n   (push_n),
        .i_push_res (step_res),
        .i_pop      (q_valid && o_out.ready),
        .o_head     (head),
        .o_valid    (q_valid),
        .o_space    (q_space)
    );

    assign o_out.valid      = q_valid;
    assign o_out.kind       = head.kind;
    assign o_out.data_byte  = head.data_byte;
    assign o_out.offset     = head.offset;
    assign o_out.length     = head.length;
    assign o_out.cert_count = head.cert_count;
    assign o_out.final_res  = head.final_res;

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import pcbe_pkg::*;

    localparam int         MARK_LEN = 27;
    localparam logic [7:0] LF       = 8'h0A;

    typedef enum bit {ROW_TEXT, ROW_CFG} t_row_op;

    // one directed step: a text piece, or a register setting
    typedef struct {
        t_row_op    op;
        string      text;
        bit         lst;
        bit         chk;
        logic [1:0] kind;
        int         offset;
        int         length;
        int         count;
        int         cap;
        int         maxc;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pcbe_in_if  in_if ();
    pcbe_out_if out_if ();
    pcbe_cfg_if cfg_if ();

    pem_certificate_base64_extractor_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    string begin_mark = "-----BEGIN CERTIFICATE-----";

    // directed stimulus; a typed result replaces the prediction for the row's last character
    t_dir_row dir_rows [19] = '{
        '{ROW_TEXT, "AZaz09+/", 1, 1, KIND_DONE, 0, 0, 0, 0, 0},
        '{ROW_TEXT, "-----BEGIN CERTIFICATE-----\n", 0, 0, KIND_DATA, 0, 0, 0, 0, 0},
        '{ROW_TEXT, "AAAA/+//=\015\n\377\200", 0, 0, KIND_DATA, 0, 0, 0, 0, 0},
        '{ROW_TEXT, "-----END", 0, 1, KIND_SECTION, 0, 6, 1, 0, 0},
        '{ROW_TEXT, "\n", 0, 0, KIND_DATA, 0, 0, 0, 0, 0},
        '{ROW_TEXT, "-----BEGIN CERTIFICATE-----\nQQ-----ENx-----Ez", 0, 0,
          KIND_DATA, 0, 0, 0, 0, 0},
        '{ROW_TEXT, "Q-----EN", 1, 0, KIND_DATA, 0, 0, 0, 0, 0},
        '{ROW_TEXT, "-----BEGIN CERT", 1, 1, KIND_DONE, 0, 0, 0, 0, 0},
        '{ROW_CFG, "", 0, 0, KIND_DATA, 0, 0, 0, 1, 1},
        '{ROW_TEXT, "-----BEGIN CERTIFICATE-----\nAAA", 0, 1, KIND_ERROR, 1, 0, 0, 0, 0},
        '{ROW_TEXT, "AA", 0, 0, KIND_DATA, 0, 0, 0, 0, 0},
        '{ROW_TEXT, "B", 1, 0, KIND_DATA, 0, 0, 0, 0, 0},
        '{ROW_CFG, "", 0, 0, KIND_DATA, 0, 0, 0, 0, 0},
        '{ROW_TEXT, "-----BEGIN CERTIFICATE-----\nAA", 0, 1, KIND_ERROR, 0, 0, 0, 0, 0},
        '{ROW_TEXT, "x", 1, 0, KIND_DATA, 0, 0, 0, 0, 0},
        '{ROW_CFG, "", 0, 0, KIND_DATA, 0, 0, 0, 65536, 0},
        '{ROW_TEXT, "-----BEGIN CERTIFICATE-----\nAAAA-----END\n", 0, 0,
          KIND_DATA, 0, 0, 0, 0, 0},
        '{ROW_TEXT, "q", 1, 1, KIND_DONE, 3, 0, 0, 0, 0},
        '{ROW_CFG, "", 0, 0, KIND_DATA, 0, 0, 0, 65536, 255}
    };

    // decoder copy: registers and parser state
    logic [16:0] cfg_cap;
    logic [7:0]  cfg_max;
    logic [2:0]  st_mode;
    int          st_match;
    int          st_dashes;
    int          st_held;
    logic [11:0] st_bits;
    int          st_nbits;
    logic [16:0] st_wpos;
    logic [16:0] st_start;
    logic [7:0]  st_seen;

    t_result     step_res [$];
    t_result     decoded_q [$];
    t_result     typed_want;
    bit          typed_on = 1'b0;
    logic [7:0]  text_buf [$];

    int          err_cnt = 0;
    int          src_idle = 0;
    int          snk_stall = 0;

    // clock
    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        #2_000_000;
        $display("[pem_certificate_base64_extractor_unit] ERROR");
        $finish;
    end

    // receiver stalls
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= snk_stall);
    end

    function automatic void clear_decoder();
        st_mode   = MODE_LINE;
        st_match  = 0;
        st_dashes = 0;
        st_held   = 0;
        st_bits   = '0;
        st_nbits  = 0;
        st_wpos   = '0;
        st_start  = '0;
        st_seen   = '0;
    endfunction

    function automatic void emit(logic [1:0] k, logic [7:0] d, logic [16:0] off,
                                 logic [16:0] len);
        t_result r;
        if (step_res.size() >= PCBE_MAX_RES) return;
        r.kind       = k;
        r.data_byte  = d;
        r.offset     = off;
        r.length     = len;
        r.cert_count = st_seen;
        r.final_res  = 1'b0;
        step_res.push_back(r);
    endfunction

    function automatic int b64_val(logic [7:0] c);
        if (c >= "A" && c <= "Z") return int'(c) - int'(8'("A"));
        if (c >= "a" && c <= "z") return int'(c) - int'(8'("a")) + 26;
        if (c >= "0" && c <= "9") return int'(c) - int'(8'("0")) + 52;
        if (c == "+") return 62;
        if (c == "/") return 63;
        return -1;
    endfunction

    function automatic logic [7:0] b64_char(int v);
        if (v < 26) return 8'(int'(8'("A")) + v);
        if (v < 52) return 8'(int'(8'("a")) + v - 26);
        if (v < 62) return 8'(int'(8'("0")) + v - 52);
        if (v == 62) return "+";
        return "/";
    endfunction

    // shift one sextet in; false once the write position reaches the capacity (overflow error)
    function automatic bit feed(logic [7:0] c);
        int v;
        v = b64_val(c);
        if (v < 0) return 1'b1;
        st_bits  = {st_bits[5:0], v[5:0]};
        st_nbits = st_nbits + 6;
        if (st_nbits >= 8) begin
            st_nbits = st_nbits - 8;
            if (st_wpos >= cfg_cap) begin
                emit(KIND_ERROR, 8'd0, st_wpos, 17'd0);
                st_mode = MODE_HALT;
                return 1'b0;
            end
            emit(KIND_DATA, 8'(st_bits >> st_nbits), st_wpos, 17'd0);
            st_wpos = st_wpos + 17'd1;
            st_bits = st_bits & ((12'd1 << st_nbits) - 12'd1);
        end
        return 1'b1;
    endfunction

    function automatic void close_section();
        if (st_wpos > st_start && st_seen < cfg_max) begin
            st_seen = st_seen + 8'd1;
            emit(KIND_SECTION, 8'd0, st_start, st_wpos - st_start);
        end
    endfunction

    // body character, with E and N held back after a dash run
    function automatic void data_char(logic [7:0] c);
        if (st_held == 1) begin
            if (c == "N") begin
                st_held = 2;
                return;
            end
            st_held = 0;
            if (!feed("E")) return;
        end else if (st_held == 2) begin
            if (c == "D") begin
                st_held   = 0;
                st_dashes = 0;
                close_section();
                st_mode = MODE_SKIPLINE;
                return;
            end
            st_held = 0;
            if (!feed("E")) return;
            if (!feed("N")) return;
        end
        if (c == "-") begin
            if (st_dashes < 5) st_dashes++;
            return;
        end
        if (c == "E" && st_dashes >= 5) begin
            st_dashes = 0;
            st_held   = 1;
            return;
        end
        st_dashes = 0;
        void'(feed(c));
    endfunction

    // predict the results of one accepted character
    function automatic void decode_char(logic [7:0] c, logic lst);
        bit      ok;
        t_result r;
        step_res.delete();
        case (st_mode)
            MODE_LINE: begin
                if (st_match < MARK_LEN && c == begin_mark[st_match]) begin
                    st_match++;
                    if (st_match >= MARK_LEN) begin
                        st_match = 0;
                        st_mode  = MODE_SKIPHDR;
                    end
                end else begin
                    st_match = 0;
                    st_mode  = (c == LF) ? MODE_LINE : MODE_SKIPLINE;
                end
            end
            MODE_SKIPLINE: begin
                if (c == LF) st_mode = MODE_LINE;
            end
            MODE_SKIPHDR: begin
                if (c == LF) begin
                    st_mode   = MODE_DATA;
                    st_start  = st_wpos;
                    st_bits   = '0;
                    st_nbits  = 0;
                    st_dashes = 0;
                    st_held   = 0;
                end
            end
            MODE_DATA: data_char(c);
            default: ;
        endcase
        // end of text: flush held letters, close, report done unless halted, rearm
        if (lst) begin
            if (st_mode == MODE_DATA) begin
                ok = 1'b1;
                if (st_held >= 1) ok = feed("E");
                if (ok && st_held == 2) ok = feed("N");
                st_held = 0;
                if (ok) close_section();
            end
            if (st_mode != MODE_HALT) emit(KIND_DONE, 8'd0, st_wpos, 17'd0);
            clear_decoder();
        end
        for (int i = 0; i < step_res.size(); i++) begin
            r = step_res[i];
            r.final_res = (i == step_res.size() - 1);
            if (typed_on && i == step_res.size() - 1) r = typed_want;
            decoded_q.push_back(r);
        end
        if (typed_on && step_res.size() == 0) decoded_q.push_back(typed_want);
        typed_on = 1'b0;
    endfunction

    function automatic void check_field(string name, logic [16:0] want_v, logic [16:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            err_cnt++;
        end
    endfunction

    // scoreboard: results first, then register writes and characters
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (decoded_q.size() == 0) begin
                    $error("result with none expected: kind %0d offset %0d",
                           out_if.kind, out_if.offset);
                    err_cnt++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("kind", 17'(want.kind), 17'(out_if.kind));
                    check_field("data_byte", 17'(want.data_byte), 17'(out_if.data_byte));
                    check_field("offset", want.offset, out_if.offset);
                    check_field("length", want.length, out_if.length);
                    check_field("cert_count", 17'(want.cert_count), 17'(out_if.cert_count));
                    check_field("final_res", 17'(want.final_res), 17'(out_if.final_res));
                end
            end
            if (cfg_if.valid && cfg_if.ready) begin
                if (cfg_if.index == CFG_DER_CAPACITY) cfg_cap = cfg_if.data;
                else if (cfg_if.index == CFG_MAX_CERTS) cfg_max = cfg_if.data[7:0];
            end
            if (in_if.valid && in_if.ready) decode_char(in_if.ch, in_if.last_char);
        end
    end

    // one character transaction, with random gaps ahead of it
    task automatic send_char(logic [7:0] c, logic lst, bit chk, t_result want);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        typed_want = want;
        typed_on   = chk;
        in_if.valid     <= 1'b1;
        in_if.ch        <= c;
        in_if.last_char <= lst;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic wait_idle();
        @(negedge i_clk) in_if.valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [16:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk) cfg_if.valid <= 1'b0;
    endtask

    task automatic set_regs(logic [16:0] cap, logic [7:0] mx);
        wait_idle();
        write_cfg(CFG_DER_CAPACITY, cap);
        write_cfg(CFG_MAX_CERTS, 17'(mx));
    endtask

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endfunction

    // certificate body: mostly base64, some dashes, line ends, padding, high bytes
    function automatic void add_body();
        int pick;
        repeat ($urandom_range(0, 10)) begin
            pick = $urandom_range(99);
            if (pick < 80) text_buf.push_back(b64_char($urandom_range(63)));
            else if (pick < 85) text_buf.push_back("-");
            else if (pick < 90) text_buf.push_back(LF);
            else if (pick < 95) text_buf.push_back("=");
            else text_buf.push_back(8'($urandom_range(128, 255)));
        end
    endfunction

    // random text: mostly certificate sections, some raw noise
    function automatic void build_text();
        int n;
        text_buf.delete();
        if ($urandom_range(99) < 20) begin
            n = $urandom_range(1, 8);
            repeat (n) text_buf.push_back(8'($urandom_range(255)));
            return;
        end
        repeat ($urandom_range(1, 2)) begin
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 5)) text_buf.push_back(8'($urandom_range(32, 126)));
                text_buf.push_back(LF);
            end
            push_str(begin_mark);
            // occasionally a broken begin marker
            if ($urandom_range(9) == 0)
                text_buf[text_buf.size() - 1 - $urandom_range(26)] = 8'($urandom_range(255));
            repeat ($urandom_range(0, 2)) text_buf.push_back(8'($urandom_range(32, 126)));
            text_buf.push_back(LF);
            add_body();
            // false end marker that releases held letters
            if ($urandom_range(99) < 20) begin
                if ($urandom_range(1) == 0) push_str("-----EN");
                else push_str("-----E");
                add_body();
            end
            if ($urandom_range(99) < 80) begin
                repeat ($urandom_range(5, 6)) text_buf.push_back("-");
                push_str("END-----");
                text_buf.push_back(LF);
            end
        end
    endfunction

    initial begin
        t_result want;
        int      sent;
        int      len;
        in_if.valid     = 1'b0;
        in_if.ch        = '0;
        in_if.last_char = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = '0;
        cfg_if.data     = '0;
        out_if.ready    = 1'b0;
        i_rst_n         = 1'b0;
        clear_decoder();
        cfg_cap = DER_CAPACITY_RST;
        cfg_max = MAX_CERTS_RST;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[r]) begin
            if (dir_rows[r].op == ROW_CFG) begin
                set_regs(17'(dir_rows[r].cap), 8'(dir_rows[r].maxc));
            end else begin
                want            = '0;
                want.kind       = dir_rows[r].kind;
                want.offset     = 17'(dir_rows[r].offset);
                want.length     = 17'(dir_rows[r].length);
                want.cert_count = 8'(dir_rows[r].count);
                want.final_res  = 1'b1;
                len = dir_rows[r].text.len();
                for (int k = 0; k < len; k++)
                    send_char(dir_rows[r].text[k], dir_rows[r].lst && k == len - 1,
                              dir_rows[r].chk && k == len - 1, want);
            end
        end

        // random texts across idling phases and register settings
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    src_idle  = 0;
                    snk_stall = 0;
                    set_regs(DER_CAPACITY_RST, MAX_CERTS_RST);
                end
                1: begin
                    src_idle  = 50;
                    snk_stall = 0;
                    set_regs(17'd1, 8'd1);
                end
                2: begin
                    src_idle  = 0;
                    snk_stall = 50;
                    set_regs(17'($urandom_range(1, 24)), 8'($urandom_range(1, 2)));
                end
                default: begin
                    src_idle  = 12;
                    snk_stall = 12;
                    set_regs(($urandom_range(1) == 0) ? DER_CAPACITY_RST
                                                      : 17'($urandom_range(1, 24)),
                             8'($urandom_range(1, 255)));
                end
            endcase
            sent = 0;
            while (sent < 20) begin
                build_text();
                foreach (text_buf[k])
                    send_char(text_buf[k], k == text_buf.size() - 1, 1'b0, '0);
                sent += text_buf.size();
            end
        end

        wait_idle();
        if (err_cnt == 0) begin
            $display("[pem_certificate_base64_extractor_unit] OK");
        end else begin
            $display("[pem_certificate_base64_extractor_unit] ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
design/pcbe_pkg.sv
design/pcbe_in_if.sv
design/pcbe_out_if.sv
design/pcbe_cfg_if.sv
design/pcbe_step.sv
design/pcbe_result_fifo.sv
design/pem_certificate_base64_extractor_unit.sv
test/testbench.sv
